// ----- design/plec_pkg.sv -----
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared constants, operation and status codes, and the cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package plec_pkg;

    // Store geometry.
    localparam int DEPTH       = 128;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int POS_W       = 8;
    localparam int CMP_W       = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 8;
    localparam int CAP_W       = 8;
    localparam int CAP_RESET   = 128;

    // Read-back reduction: cells are ORed in groups, then the groups are ORed.
    localparam int GROUP_SIZE  = 16;
    localparam int NUM_GROUPS  = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_GET    = 2'd3
    } op_t;

    // Status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Control word broadcast to every cell of the row.
    typedef struct packed {
        logic             insert_en;
        logic             delete_en;
        logic             update_en;
        logic             read_en;
        logic [CMP_W-1:0] pos0;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/positional_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// Positional list engine core
// Bounded ordered list in a row of cells with insert, delete, update and get.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the input channel (in_valid / in_stall) carrying
//   operation, position (1-based) and value. Each accepted word yields exactly
//   one result word on the output channel (out_valid / out_stall) carrying
//   status, read_value and entry_count.
//   The capacity register is written through cfg_valid / cfg_ready / cfg_data;
//   cfg_ready is always high. Write it only while no request is in flight.
//   Every cell updates at the edge the request is accepted, so the whole shift
//   of an insert or delete is done at that edge. Read-back goes through a
//   two-level registered OR tree (groups of 16 cells, then the groups): a
//   result passes the group registers, then the output register. The block
//   takes one request per cycle as long as the output side keeps up.
//   When the receiver stalls, the result waits in the output register and one
//   more request can be held in the tree stage; after that in_stall rises.
//   Reset empties the list (count zero), sets capacity to 128 and clears both
//   pipeline stages; the cell contents are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration write channel.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [plec_pkg::CAP_W-1:0]         cfg_data,
    // Request channel.
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         operation,
    input  wire logic [plec_pkg::POS_W-1:0]         position,
    input  wire logic signed [plec_pkg::DATA_W-1:0] value,
    // Result channel.
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [1:0]                              status,
    output logic signed [plec_pkg::DATA_W-1:0]      read_value,
    output logic [plec_pkg::COUNT_W-1:0]            entry_count
);

    localparam int DW = plec_pkg::DATA_W;

    logic [plec_pkg::CAP_W-1:0]   capacity_reg;
    logic [plec_pkg::COUNT_W-1:0] count_reg;
    logic [plec_pkg::COUNT_W-1:0] count_next;

    logic                         s1_valid_reg;
    logic [1:0]                   s1_status_reg;
    logic [plec_pkg::COUNT_W-1:0] s1_count_reg;
    logic [DW-1:0]                grp_reg [plec_pkg::NUM_GROUPS];
    logic [DW-1:0]                grp_next [plec_pkg::NUM_GROUPS];

    logic                         out_valid_reg;
    logic [1:0]                   status_reg;
    logic [DW-1:0]                read_value_reg;
    logic [plec_pkg::COUNT_W-1:0] entry_count_reg;

    logic                         accept;
    logic                         advance;
    logic                         full;
    logic                         ins_ok;
    logic                         pos_ok;
    logic                         done;
    logic [1:0]                   req_status;
    logic [plec_pkg::POS_W-1:0]   pos0;
    logic [DW-1:0]                tree_or;
    plec_pkg::cell_ctrl_t         ctrl;

    logic [DW-1:0]                cell_data [plec_pkg::DEPTH];
    logic [DW-1:0]                cell_rd   [plec_pkg::DEPTH];

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;

    // Request checks: full comes before the position check on insert.
    assign full   = (count_reg >= capacity_reg)
                 || (32'(count_reg) >= plec_pkg::DEPTH);
    assign ins_ok = (position != '0)
                 && ({1'b0, position} <= ({1'b0, count_reg} + 9'd1));
    assign pos_ok = (position != '0) && (position <= count_reg);

    always_comb
    begin
        req_status = plec_pkg::ST_DONE;
        if (operation == plec_pkg::OP_INSERT)
        begin
            if (full)
                req_status = plec_pkg::ST_FULL;
            else if (!ins_ok)
                req_status = plec_pkg::ST_RANGE;
        end
        else if (!pos_ok)
        begin
            req_status = plec_pkg::ST_RANGE;
        end
    end

    assign done = accept && (req_status == plec_pkg::ST_DONE);
    assign pos0 = position - plec_pkg::POS_W'(1);

    // Control word for the cell row.
    always_comb
    begin
        ctrl.insert_en = done && (operation == plec_pkg::OP_INSERT);
        ctrl.delete_en = done && (operation == plec_pkg::OP_DELETE);
        ctrl.update_en = done && (operation == plec_pkg::OP_UPDATE);
        ctrl.read_en   = done && ((operation == plec_pkg::OP_DELETE)
                                || (operation == plec_pkg::OP_GET));
        ctrl.pos0      = plec_pkg::CMP_W'(pos0);
    end

    // Entry count after the request.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert_en)
            count_next = count_reg + plec_pkg::COUNT_W'(1);
        else if (ctrl.delete_en)
            count_next = count_reg - plec_pkg::COUNT_W'(1);
    end

    // Row of cells; the ends wrap to harmless inputs.
    for (genvar i = 0; i < plec_pkg::DEPTH; i++)
    begin : g_cell
        logic [DW-1:0] left_in;
        logic [DW-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = value;
        end
        else
        begin : g_mid_l
            assign left_in = cell_data[i-1];
        end

        if (i == plec_pkg::DEPTH - 1)
        begin : g_last
            assign right_in = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_in = cell_data[i+1];
        end

        plec_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .value      (value),
            .cell_index (plec_pkg::IDX_W'(i)),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // First level of the read-back tree: OR within each group of cells.
    always_comb
    begin
        for (int g = 0; g < plec_pkg::NUM_GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < plec_pkg::GROUP_SIZE; k++)
            begin
                if (g * plec_pkg::GROUP_SIZE + k < plec_pkg::DEPTH)
                    grp_next[g] = grp_next[g] | cell_rd[g * plec_pkg::GROUP_SIZE + k];
            end
        end
    end

    // Second level: OR across the registered groups.
    always_comb
    begin
        tree_or = '0;
        for (int g = 0; g < plec_pkg::NUM_GROUPS; g++)
            tree_or = tree_or | grp_reg[g];
    end

    // Control state: capacity, count and stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= plec_pkg::CAP_W'(plec_pkg::CAP_RESET);
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                capacity_reg <= cfg_data;
            count_reg <= count_next;
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers of the two stages.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= req_status;
            s1_count_reg  <= count_next;
            for (int g = 0; g < plec_pkg::NUM_GROUPS; g++)
                grp_reg[g] <= grp_next[g];
        end
        if (advance)
        begin
            status_reg      <= s1_status_reg;
            entry_count_reg <= s1_count_reg;
            read_value_reg  <= tree_or;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;

endmodule

`default_nettype wire

// ----- design/plec_cell.sv -----
// ----------------------------------------------------------------------------
// Positional list engine cell
// Holds one list entry and moves it to or from its neighbors on insert/delete.
// ----------------------------------------------------------------------------
`default_nettype none

module plec_cell (
    input  wire logic                          clk,
    input  wire plec_pkg::cell_ctrl_t          ctrl,
    input  wire logic [plec_pkg::DATA_W-1:0]   value,
    input  wire logic [plec_pkg::IDX_W-1:0]    cell_index,
    input  wire logic [plec_pkg::DATA_W-1:0]   left_data,
    input  wire logic [plec_pkg::DATA_W-1:0]   right_data,
    output logic      [plec_pkg::DATA_W-1:0]   data,
    output logic      [plec_pkg::DATA_W-1:0]   rd_data
);

    logic [plec_pkg::DATA_W-1:0] data_reg;
    logic [plec_pkg::DATA_W-1:0] data_next;
    logic [plec_pkg::CMP_W-1:0]  my_index;
    logic                        at_pos;
    logic                        above_pos;

    // Compare this cell's place with the target position.
    assign my_index  = plec_pkg::CMP_W'(cell_index);
    assign at_pos    = (my_index == ctrl.pos0);
    assign above_pos = (my_index > ctrl.pos0);

    // Next entry: shift up on insert, shift down on delete, load on a hit.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.insert_en)
        begin
            if (above_pos)
                data_next = left_data;
            else if (at_pos)
                data_next = value;
        end
        else if (ctrl.delete_en)
        begin
            if (above_pos || at_pos)
                data_next = right_data;
        end
        else if (ctrl.update_en)
        begin
            if (at_pos)
                data_next = value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;

    // The addressed cell drives its old entry into the read-back OR tree.
    assign rd_data = (ctrl.read_en && at_pos) ? data_reg : '0;

endmodule

`default_nettype wire

// ----- dv/positional_list_engine_core_tb.sv -----
// ----------------------------------------------------------------------------
// Positional list engine core testbench
// Sends request words through the valid/stall channel and keeps a shadow copy
// of the list and the capacity register. Every result word is checked against
// the shadow, field by field, in order.
// ----------------------------------------------------------------------------

module positional_list_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plec_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   read_value;
        logic [COUNT_W-1:0]  entry_count;
    } list_result_t;

    // Block ports; the inputs are driven to known values from time zero.
    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      cfg_valid   = 1'b0;
    logic                      cfg_ready;
    logic [CAP_W-1:0]          cfg_data    = '0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic [1:0]                operation   = '0;
    logic [POS_W-1:0]          position    = '0;
    logic signed [DATA_W-1:0]  value       = '0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic [1:0]                status;
    logic signed [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0]        entry_count;

    // Shadow of the list contents, its length and the capacity register.
    logic [DATA_W-1:0]  shadow_list [DEPTH];
    int                 shadow_len  = 0;
    int                 cap_setting = CAP_RESET;
    bit                 grow_list   = 1'b1;

    // Results owed by the block, oldest first.
    list_result_t       pending_results [$];

    int error_count    = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int hold_off_left  = 0;

    positional_list_engine_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .position    (position),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

    always #10 clk = ~clk;

    // Print one error line and count it.
    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        error_count++;
    endtask

    // Apply one request to the shadow list and return the result it owes.
    function automatic list_result_t apply_list_op(input op_t op, input int pos,
                                                   input logic [DATA_W-1:0] val);
        list_result_t res;
        int           lim;
        int           i;
        res.status     = ST_DONE;
        res.read_value = '0;
        lim = (cap_setting < DEPTH) ? cap_setting : DEPTH;
        if (op == OP_INSERT)
        begin
            // The full check wins over the position check.
            if (shadow_len >= lim)
                res.status = ST_FULL;
            else if (pos < 1 || pos > shadow_len + 1)
                res.status = ST_RANGE;
            else
            begin
                for (i = shadow_len; i > pos - 1; i--)
                    shadow_list[i] = shadow_list[i - 1];
                shadow_list[pos - 1] = val;
                shadow_len++;
            end
        end
        else if (pos < 1 || pos > shadow_len)
            res.status = ST_RANGE;
        else if (op == OP_DELETE)
        begin
            res.read_value = shadow_list[pos - 1];
            for (i = pos - 1; i + 1 < shadow_len; i++)
                shadow_list[i] = shadow_list[i + 1];
            shadow_len--;
        end
        else if (op == OP_UPDATE)
            shadow_list[pos - 1] = val;
        else
            res.read_value = shadow_list[pos - 1];
        res.entry_count = COUNT_W'(shadow_len);
        return res;
    endfunction

    // Offer one request word, possibly after idle cycles, and wait for it to be taken.
    task automatic issue_request(input op_t op, input logic [POS_W-1:0] pos,
                                 input logic [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        position  <= pos;
        value     <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(apply_list_op(op, pos, val));
    endtask

    // Stop sending and wait until every owed result word has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the capacity register once the block has gone quiet.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cap_setting = cap;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Choose a random request. Most are well formed and drift the list between
    // empty and full; the rest are near misses on the position or pure noise.
    task automatic pick_request(output op_t op, output logic [POS_W-1:0] pos,
                                output logic [DATA_W-1:0] val);
        int mode;
        int roll;
        int lim;
        lim  = (cap_setting < DEPTH) ? cap_setting : DEPTH;
        mode = $urandom_range(99);
        val  = $urandom;
        if ($urandom_range(9) == 0)
            val = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        if (shadow_len >= lim)
            grow_list = 1'b0;
        else if (shadow_len == 0)
            grow_list = 1'b1;

        if (mode < 8)
        begin
            op  = op_t'($urandom_range(3));
            pos = POS_W'($urandom_range(255));
        end
        else if (mode < 16)
        begin
            op = op_t'($urandom_range(3));
            case ($urandom_range(2))
                0:       pos = '0;
                1:       pos = POS_W'((op == OP_INSERT) ? shadow_len + 2 : shadow_len + 1);
                default: pos = POS_W'(shadow_len + 2 + $urandom_range(8));
            endcase
        end
        else
        begin
            roll = $urandom_range(99);
            if (shadow_len == 0 || roll < (grow_list ? 45 : 15))
                op = OP_INSERT;
            else if (roll < 60)
                op = OP_DELETE;
            else if (roll < 80)
                op = OP_UPDATE;
            else
                op = OP_GET;
            if (op == OP_INSERT)
                pos = POS_W'($urandom_range(shadow_len + 1, 1));
            else
                pos = POS_W'($urandom_range(shadow_len, 1));
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            out_stall <= 1'b1;
            hold_off_left--;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check each accepted result word against the oldest expectation.
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_error($sformatf("unexpected result: status %0d read %08h count %0d",
                                       status, read_value, entry_count));
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_error($sformatf("status %0d, expected %0d", status, want.status));
                if (read_value !== want.read_value)
                    report_error($sformatf("read_value %08h, expected %08h",
                                           read_value, want.read_value));
                if (entry_count !== want.entry_count)
                    report_error($sformatf("entry_count %0d, expected %0d",
                                           entry_count, want.entry_count));
            end
        end
    end

    // Edges of every operation on a short list, starting from empty.
    task automatic test_directed_ops();
        int p;
        issue_request(OP_GET,    1, 32'h0);
        issue_request(OP_DELETE, 1, 32'h0);
        issue_request(OP_UPDATE, 0, 32'h1234_5678);
        issue_request(OP_INSERT, 0, 32'h1);
        issue_request(OP_INSERT, 2, 32'h2);
        // Build the list at the front, the back and the middle.
        issue_request(OP_INSERT, 1, 32'h7FFF_FFFF);
        issue_request(OP_INSERT, 1, 32'h8000_0000);
        issue_request(OP_INSERT, 3, 32'hFFFF_FFFF);
        issue_request(OP_INSERT, 2, 32'h0);
        issue_request(OP_INSERT, 6, 32'h5);
        for (p = 1; p <= 5; p++)
            issue_request(OP_GET, POS_W'(p), 32'h0);
        issue_request(OP_UPDATE, 4, 32'hA5A5_5A5A);
        issue_request(OP_GET,    4, 32'h0);
        issue_request(OP_DELETE, 2, 32'h0);
        issue_request(OP_DELETE, 3, 32'h0);
        issue_request(OP_GET,    255, 32'h0);
        issue_request(OP_INSERT, 255, 32'h3);
        issue_request(OP_DELETE, 1, 32'h0);
    endtask

    // Zero capacity, capacity of one, capacity above the store depth, and capacity below the count.
    task automatic test_capacity_limits();
        write_capacity(8'd0);
        issue_request(OP_INSERT, 1, $urandom);
        issue_request(OP_INSERT, 0, $urandom);
        issue_request(OP_GET,    1, 32'h0);

        write_capacity(8'd1);
        issue_request(OP_INSERT, 1, $urandom);
        issue_request(OP_DELETE, 1, 32'h0);
        issue_request(OP_INSERT, 1, $urandom);
        issue_request(OP_INSERT, 2, $urandom);

        // The store depth still bounds the list when the register is larger.
        write_capacity(8'd255);
        while (shadow_len < DEPTH)
            issue_request(OP_INSERT, POS_W'($urandom_range(shadow_len + 1, 1)), $urandom);
        issue_request(OP_INSERT, POS_W'(DEPTH + 1), $urandom);
        issue_request(OP_INSERT, 1, $urandom);
        issue_request(OP_GET,    POS_W'(DEPTH), 32'h0);
        issue_request(OP_UPDATE, POS_W'(DEPTH), $urandom);
        issue_request(OP_GET,    POS_W'(DEPTH + 1), 32'h0);

        // Entries survive a lower limit; inserts are refused as full until deletes make room.
        write_capacity(8'd10);
        issue_request(OP_INSERT, 1, $urandom);
        issue_request(OP_GET,    POS_W'($urandom_range(shadow_len, 1)), 32'h0);
        issue_request(OP_UPDATE, POS_W'($urandom_range(shadow_len, 1)), $urandom);
        while (shadow_len > 9)
            issue_request(OP_DELETE, POS_W'($urandom_range(shadow_len, 1)), 32'h0);
        issue_request(OP_INSERT, POS_W'($urandom_range(shadow_len + 1, 1)), $urandom);
        issue_request(OP_INSERT, 1, $urandom);
    endtask

    // Random traffic under one capacity setting and one idling pattern.
    task automatic test_random_phase(input int n_items, input int idle_pct,
                                     input int stall_in_pct, input logic [CAP_W-1:0] cap);
        op_t               op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        write_capacity(cap);
        send_idle_pct = idle_pct;
        stall_pct     = stall_in_pct;
        repeat (n_items)
        begin
            pick_request(op, pos, val);
            issue_request(op, pos, val);
        end
    endtask

    // Hold the result side off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        op_t               op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        write_capacity(8'd128);
        send_idle_pct = 0;
        stall_pct     = 0;
        @(posedge clk);
        hold_off_left = 60;
        repeat (40)
        begin
            pick_request(op, pos, val);
            issue_request(op, pos, val);
        end
    endtask

    // Test sequence.
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_capacity_limits();
        test_random_phase(170, 0,  0,  8'd128);
        test_random_phase(170, 47, 0,  8'd7);
        test_random_phase(170, 0,  47, 8'd1);
        test_random_phase(170, 17, 17, 8'd60);
        test_backpressure();

        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("positional_list_engine_core verification clean");
        else
            $display("positional_list_engine_core verification failed");
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial
    begin
        #2_000_000;
        $display("positional_list_engine_core verification failed");
        $finish;
    end

endmodule
